/* sv/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, constants and helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int CAPACITY    = 64;
  localparam int PTR_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int WORD_W      = 32;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } dq_op_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } dq_err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } dq_state_e;

  typedef struct packed {
    logic latch_in;
    logic ram_we;
    logic ram_re;
    logic commit;
  } dq_cmd_t;

  typedef struct packed {
    logic is_push;
    logic full;
    logic empty;
    logic out_free;
  } dq_status_t;

  // Adds an offset to a ring index, wrapping at the capacity.
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                               input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, ptr} + {1'b0, off};
    if (sum >= (PTR_W+1)'(CAPACITY)) begin
      sum = sum - (PTR_W+1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

/* sv/dq_if.sv */
// ----------------------------------------------------------------------------
// dq_in_if / dq_out_if
// Valid/ready channels that carry one operation word in and one result word out.
// ----------------------------------------------------------------------------
interface dq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface dq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] popped_value;
  logic [1:0]         error_code;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic               is_empty;
  logic [6:0]         entry_count;

  modport source (output valid, output popped_value, output error_code,
                  output front_value, output back_value, output is_empty,
                  output entry_count, input ready);
  modport sink   (input valid, input popped_value, input error_code,
                  input front_value, input back_value, input is_empty,
                  input entry_count, output ready);
endinterface

/* sv/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer that takes one operation, runs the storage access and commits.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dq_pkg::dq_status_t status_i,
  output dq_pkg::dq_cmd_t    cmd_o
);
  import dq_pkg::*;

  dq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.ram_we = status_i.is_push && !status_i.full;
        cmd_o.ram_re = !status_i.is_push && !status_i.empty;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/dq_datapath.sv */
// ----------------------------------------------------------------------------
// dq_datapath
// Ring pointers, cached end words, entry storage and the result register.
// ----------------------------------------------------------------------------
module dq_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] push_value_i,
  input  dq_pkg::dq_cmd_t    cmd_i,
  output dq_pkg::dq_status_t status_o,
  dq_out_if.source           out_o
);
  import dq_pkg::*;

  dq_op_e              op_q;
  logic [WORD_W-1:0]   value_q;
  logic [PTR_W-1:0]    front_ptr_q, front_ptr_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [WORD_W-1:0]   front_word_q, front_word_d;
  logic [WORD_W-1:0]   back_word_q, back_word_d;
  logic                out_valid_q, out_valid_d;
  logic [WORD_W-1:0]   popped_q, popped_d;
  dq_err_e             err_q, err_d;

  logic [PTR_W-1:0]    front_dec;
  logic [PTR_W-1:0]    front_inc;
  logic [PTR_W-1:0]    back_slot;
  logic [PTR_W-1:0]    before_back;
  logic [PTR_W-1:0]    ram_waddr;
  logic [PTR_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;
  logic                full;
  logic                empty;
  logic                is_push;
  logic                out_free;

  assign full      = (count_q == CNT_W'(CAPACITY));
  assign empty     = (count_q == '0);
  assign is_push   = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);
  assign out_free  = !out_valid_q || out_o.ready;

  assign front_dec   = ptr_add(front_ptr_q, PTR_W'(CAPACITY - 1));
  assign front_inc   = ptr_add(front_ptr_q, PTR_W'(1));
  assign back_slot   = ptr_add(front_ptr_q, PTR_W'(count_q));
  assign before_back = ptr_add(front_ptr_q, PTR_W'(count_q - CNT_W'(2)));

  assign ram_waddr = (op_q == OP_PUSH_FRONT) ? front_dec : back_slot;
  assign ram_raddr = (op_q == OP_POP_FRONT) ? front_inc : before_back;

  assign status_o.is_push  = is_push;
  assign status_o.full     = full;
  assign status_o.empty    = empty;
  assign status_o.out_free = out_free;

  dq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(value_q),
    .re_i   (cmd_i.ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q    <= dq_op_e'(operation_i);
      value_q <= push_value_i;
    end
    if (cmd_i.commit) begin
      popped_q <= popped_d;
      err_q    <= err_d;
    end
  end

  always_comb begin
    front_ptr_d  = front_ptr_q;
    count_d      = count_q;
    front_word_d = front_word_q;
    back_word_d  = back_word_q;
    popped_d     = '0;
    err_d        = ERR_NONE;
    case (op_q) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          err_d = ERR_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
          if (op_q == OP_PUSH_FRONT) begin
            front_ptr_d  = front_dec;
            front_word_d = value_q;
            if (empty) begin
              back_word_d = value_q;
            end
          end else begin
            back_word_d = value_q;
            if (empty) begin
              front_word_d = value_q;
            end
          end
        end
      end
      default: begin
        if (empty) begin
          err_d = ERR_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
          if (op_q == OP_POP_FRONT) begin
            popped_d    = front_word_q;
            front_ptr_d = front_inc;
            if (count_d == '0) begin
              front_word_d = '0;
              back_word_d  = '0;
            end else if (count_d == CNT_W'(1)) begin
              front_word_d = back_word_q;
            end else begin
              front_word_d = ram_rdata;
            end
          end else begin
            popped_d = back_word_q;
            if (count_d == '0) begin
              front_word_d = '0;
              back_word_d  = '0;
            end else if (count_d == CNT_W'(1)) begin
              back_word_d = front_word_q;
            end else begin
              back_word_d = ram_rdata;
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_ptr_q  <= '0;
      count_q      <= '0;
      front_word_q <= '0;
      back_word_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.commit) begin
        front_ptr_q  <= front_ptr_d;
        count_q      <= count_d;
        front_word_q <= front_word_d;
        back_word_q  <= back_word_d;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = popped_q;
  assign out_o.error_code   = err_q;
  assign out_o.front_value  = front_word_q;
  assign out_o.back_value   = back_word_q;
  assign out_o.is_empty     = (count_q == '0);
  assign out_o.entry_count  = COUNT_OUT_W'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_ptr_q < PTR_W'(CAPACITY - 1) || front_ptr_q == PTR_W'(CAPACITY - 1))
    else $error("Front pointer is outside the ring.");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> front_word_q == '0 && back_word_q == '0)
    else $error("Cached end words are not zero while the queue is empty.");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> out_free)
    else $error("Result committed while the output register is occupied.");

  a_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.ram_we && cmd_i.ram_re))
    else $error("Storage written and read in the same cycle.");

endmodule

/* sv/double_ended_queue_top.sv */
// Bounded double-ended queue of 64 signed 32-bit words. Each input word asks
// for a push or a pop at either end, and each one yields exactly one result
// word with the popped value, an error code and the front, back, empty and
// count status after the operation. One operation is in flight at a time: an
// accepted word goes through capture, storage access and commit, and the commit
// waits until the output register is free; the result is registered at commit.
// The storage access step serves the entry storage with its registered read,
// which a pop uses to fetch the new end word. Input is accepted even while an
// earlier result still waits at the output. No clearing pass follows reset; a
// word read from storage is used only if its entry was written.
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Top level joining the sequencer and the queue datapath.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  dq_in_if.sink     in_i,
  dq_out_if.source  out_o
);
  import dq_pkg::*;

  dq_cmd_t    cmd;
  dq_status_t status;

  dq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  dq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operation_i (in_i.operation),
    .push_value_i(in_i.push_value),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_o       (out_o)
  );

endmodule
